// ===== rtl/dfrt_pkg.sv =====
package dfrt_pkg;

  localparam int unsigned OPEN_SLOTS_DEF = 8;
  localparam int unsigned MAX_PARTS_DEF  = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [15:0] PAYLOAD_SIZE_RST = 16'd500;
  localparam logic [16:0] HDR_BYTES        = 17'd8;
  localparam logic [7:0]  SINGLE_PART      = 8'd1;
  localparam logic [24:0] BYTES_MAX        = 25'hFF_FFFF;

  typedef enum logic [2:0] {
    ST_PARTIAL        = 3'd0,
    ST_DONE           = 3'd1,
    ST_LEN_ERR        = 3'd2,
    ST_COUNT_MISMATCH = 3'd3,
    ST_BAD_PART       = 3'd4,
    ST_TABLE_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CLS_OK,
    CLS_LEN_ERR,
    CLS_BAD_PART
  } cls_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_HIT,
    BK_MISS
  } bk_state_e;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] id;
    logic [7:0]  count;
    logic [7:0]  idx;
    logic [15:0] psize;
    logic [7:0]  src;
    logic [23:0] offs;
  } frag_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [23:0] offs;
    logic [31:0] id;
    logic [23:0] total;
    logic [7:0]  src;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  total;
    logic [7:0]  seen;
    logic [23:0] bytes;
  } entry_t;

endpackage

// ===== rtl/datagram_fragment_reassembly_tracker_top.sv =====
// Path: a fragment that fails the length or index/size check passes the queue and then the result
//   register; any other one also walks the slot table from slot 0 until its id is found or all are read.
// Throughput: one rejected fragment per cycle while the result side keeps popping; any other one
//   holds the back end for the slot table walk through its single read port, one entry a cycle.
// Reset: all slots free, fragment_payload_size = 500, queues empty; no clearing pass is needed,
//   since a slot entry and its part bitmap are rewritten in full when the slot is allocated.
module datagram_fragment_reassembly_tracker_top #(
  parameter int unsigned OPEN_SLOTS = dfrt_pkg::OPEN_SLOTS_DEF,
  parameter int unsigned MAX_PARTS  = dfrt_pkg::MAX_PARTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel: fragment_payload_size
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // fragment header queue side
  input  logic        push,
  output logic        full,
  input  logic [31:0] message_id_i,
  input  logic [7:0]  part_count_i,
  input  logic [7:0]  part_index_i,
  input  logic [15:0] part_size_i,
  input  logic [16:0] datagram_length_i,
  input  logic [7:0]  source_tag_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [2:0]  slot_o,
  output logic [23:0] write_offset_o,
  output logic [31:0] done_id_o,
  output logic [23:0] total_size_o,
  output logic [7:0]  last_source_o
);
  import dfrt_pkg::*;

  frag_t   front_item;
  frag_t   q_item;
  logic    q_empty;
  logic    q_pop;
  result_t res;

  // Front: hold the stride register, check length and index/size, form the write offset.
  dfrt_front #(
    .MAX_PARTS (MAX_PARTS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .message_id_i      (message_id_i),
    .part_count_i      (part_count_i),
    .part_index_i      (part_index_i),
    .part_size_i       (part_size_i),
    .datagram_length_i (datagram_length_i),
    .source_tag_i      (source_tag_i),
    .item_o            (front_item)
  );

  // Short queue of classified fragments; a transaction on push lands here directly.
  dfrt_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .full_o  (full),
    .item_i  (front_item),
    .rd_i    (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  // Back: walk the slot table, update or allocate, and hold the result until popped.
  dfrt_back #(
    .OPEN_SLOTS (OPEN_SLOTS),
    .MAX_PARTS  (MAX_PARTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .item_i    (q_item),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign status_o       = res.status;
  assign slot_o         = res.slot;
  assign write_offset_o = res.offs;
  assign done_id_o      = res.id;
  assign total_size_o   = res.total;
  assign last_source_o  = res.src;

endmodule

// ===== rtl/dfrt_front.sv =====
module dfrt_front #(
  parameter int unsigned MAX_PARTS = dfrt_pkg::MAX_PARTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic [31:0]       message_id_i,
  input  logic [7:0]        part_count_i,
  input  logic [7:0]        part_index_i,
  input  logic [15:0]       part_size_i,
  input  logic [16:0]       datagram_length_i,
  input  logic [7:0]        source_tag_i,
  output dfrt_pkg::frag_t   item_o
);
  import dfrt_pkg::*;

  logic [15:0] fps_q;
  logic        len_ok;
  logic        bad_part;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= PAYLOAD_SIZE_RST;
    end else if (cfg_valid_i) begin
      fps_q <= cfg_data_i;
    end
  end

  always_comb begin
    len_ok   = (datagram_length_i == ({1'b0, part_size_i} + HDR_BYTES));
    bad_part = ({1'b0, part_index_i} >= {1'b0, part_count_i}) ||
               ({1'b0, part_index_i} >= 9'(MAX_PARTS)) ||
               (part_size_i > fps_q);

    item_o.id    = message_id_i;
    item_o.count = part_count_i;
    item_o.idx   = part_index_i;
    item_o.psize = part_size_i;
    item_o.src   = source_tag_i;
    item_o.offs  = 24'(part_index_i) * 24'(fps_q);
    if (!len_ok) begin
      item_o.cls = CLS_LEN_ERR;
    end else if (bad_part) begin
      item_o.cls = CLS_BAD_PART;
    end else begin
      item_o.cls = CLS_OK;
    end
  end

endmodule

// ===== rtl/dfrt_fifo.sv =====
module dfrt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  output logic            full_o,
  input  dfrt_pkg::frag_t item_i,
  input  logic            rd_i,
  output logic            empty_o,
  output dfrt_pkg::frag_t item_o
);
  import dfrt_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  frag_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/dfrt_back.sv =====
module dfrt_back #(
  parameter int unsigned OPEN_SLOTS = dfrt_pkg::OPEN_SLOTS_DEF,
  parameter int unsigned MAX_PARTS  = dfrt_pkg::MAX_PARTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  dfrt_pkg::frag_t   item_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dfrt_pkg::result_t res_o
);
  import dfrt_pkg::*;

  localparam int unsigned SW = (OPEN_SLOTS > 1) ? $clog2(OPEN_SLOTS) : 1;
  localparam int unsigned PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

  bk_state_e             state_q, state_d;
  frag_t                 work_q, work_d;
  logic [SW-1:0]         chk_q, chk_d;
  logic [SW-1:0]         free_q, free_d;
  logic                  free_vld_q, free_vld_d;
  logic [OPEN_SLOTS-1:0] valid_q, valid_d;
  logic                  out_vld_q, out_vld_d;
  result_t               out_q, out_d;

  entry_t                ent_mem [OPEN_SLOTS];
  logic [MAX_PARTS-1:0]  row_mem [OPEN_SLOTS];
  entry_t                ent_rd_q;
  logic [MAX_PARTS-1:0]  row_rd_q;
  logic [SW-1:0]         rd_addr, wr_addr;
  logic                  we;
  entry_t                ent_wr;
  logic [MAX_PARTS-1:0]  row_wr;

  logic                  out_free;
  logic                  hit;
  logic                  seen_bit;
  logic [MAX_PARTS-1:0]  bit_mask;
  logic [24:0]           sum;
  logic [23:0]           bytes_new;
  logic [7:0]            seen_new;

  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      ent_mem[wr_addr] <= ent_wr;
      row_mem[wr_addr] <= row_wr;
    end
    ent_rd_q <= ent_mem[rd_addr];
    row_rd_q <= row_mem[rd_addr];
  end

  always_comb begin
    out_free = !out_vld_q || pop_i;
    hit      = valid_q[chk_q] && (ent_rd_q.id == work_q.id);
    seen_bit = row_rd_q[work_q.idx[PW-1:0]];
    bit_mask = '0;
    bit_mask[work_q.idx[PW-1:0]] = 1'b1;
    sum      = {1'b0, ent_rd_q.bytes} + 25'(work_q.psize);
    if (seen_bit) begin
      bytes_new = ent_rd_q.bytes;
    end else if (sum > BYTES_MAX) begin
      bytes_new = BYTES_MAX[23:0];
    end else begin
      bytes_new = sum[23:0];
    end
    seen_new = ent_rd_q.seen + 8'(!seen_bit);

    state_d    = state_q;
    work_d     = work_q;
    chk_d      = chk_q;
    free_d     = free_q;
    free_vld_d = free_vld_q;
    valid_d    = valid_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_d      = out_q;
    q_pop_o    = 1'b0;
    rd_addr    = chk_q;
    wr_addr    = chk_q;
    we         = 1'b0;
    ent_wr     = ent_rd_q;
    row_wr     = row_rd_q;

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          work_d  = item_i;
          case (item_i.cls)
            CLS_LEN_ERR: begin
              out_vld_d    = 1'b1;
              out_d        = '0;
              out_d.status = ST_LEN_ERR;
            end
            CLS_BAD_PART: begin
              out_vld_d    = 1'b1;
              out_d        = '0;
              out_d.status = ST_BAD_PART;
            end
            default: begin
              rd_addr    = '0;
              chk_d      = '0;
              free_vld_d = 1'b0;
              state_d    = BK_SCAN;
            end
          endcase
        end
      end

      BK_SCAN: begin
        if (!valid_q[chk_q] && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_d     = chk_q;
        end
        if (hit) begin
          state_d = BK_HIT;
        end else if (chk_q == SW'(OPEN_SLOTS - 1)) begin
          state_d = BK_MISS;
        end else begin
          rd_addr = chk_q + 1'b1;
          chk_d   = chk_q + 1'b1;
        end
      end

      BK_HIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = '0;
          out_d.slot = 3'(chk_q);
          state_d    = BK_IDLE;
          if (ent_rd_q.total != work_q.count) begin
            out_d.status = ST_COUNT_MISMATCH;
          end else begin
            we           = 1'b1;
            ent_wr.seen  = seen_new;
            ent_wr.bytes = bytes_new;
            row_wr       = row_rd_q | bit_mask;
            out_d.offs   = work_q.offs;
            out_d.total  = bytes_new;
            out_d.src    = work_q.src;
            if (seen_new >= ent_rd_q.total) begin
              valid_d[chk_q] = 1'b0;
              out_d.status   = ST_DONE;
              out_d.id       = work_q.id;
            end else begin
              out_d.status = ST_PARTIAL;
            end
          end
        end
      end

      BK_MISS: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '0;
          state_d   = BK_IDLE;
          if (work_q.count == SINGLE_PART) begin
            out_d.status = ST_DONE;
            out_d.offs   = work_q.offs;
            out_d.id     = work_q.id;
            out_d.total  = 24'(work_q.psize);
            out_d.src    = work_q.src;
          end else if (!free_vld_q) begin
            out_d.status = ST_TABLE_FULL;
          end else begin
            we              = 1'b1;
            wr_addr         = free_q;
            ent_wr.id       = work_q.id;
            ent_wr.total    = work_q.count;
            ent_wr.seen     = SINGLE_PART;
            ent_wr.bytes    = 24'(work_q.psize);
            row_wr          = bit_mask;
            valid_d[free_q] = 1'b1;
            out_d.status    = ST_PARTIAL;
            out_d.slot      = 3'(free_q);
            out_d.offs      = work_q.offs;
            out_d.total     = 24'(work_q.psize);
            out_d.src       = work_q.src;
          end
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      out_vld_q  <= out_vld_d;
      free_vld_q <= free_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    chk_q  <= chk_d;
    free_q <= free_d;
    out_q  <= out_d;
  end

endmodule

// ===== bench/reassembly_checker.sv =====
module reassembly_checker #(
  parameter int unsigned OPEN_SLOTS = dfrt_pkg::OPEN_SLOTS_DEF,
  parameter int unsigned MAX_PARTS  = dfrt_pkg::MAX_PARTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [31:0] message_id_i,
  input  logic [7:0]  part_count_i,
  input  logic [7:0]  part_index_i,
  input  logic [15:0] part_size_i,
  input  logic [16:0] datagram_length_i,
  input  logic [7:0]  source_tag_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [2:0]  status_i,
  input  logic [2:0]  slot_i,
  input  logic [23:0] write_offset_i,
  input  logic [31:0] done_id_i,
  input  logic [23:0] total_size_i,
  input  logic [7:0]  last_source_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfrt_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [15:0]          payload_size;
  logic                 slot_open [OPEN_SLOTS];
  entry_t               slot_entry [OPEN_SLOTS];
  logic [MAX_PARTS-1:0] part_map [OPEN_SLOTS];
  result_t              reassembly_q [$];
  int                   fails;

  function automatic result_t track_fragment(input logic [31:0] id, input logic [7:0] cnt,
                                             input logic [7:0] idx, input logic [15:0] psize,
                                             input logic [16:0] dlen, input logic [7:0] src);
    result_t     r;
    int          hit;
    int          vacant;
    logic [24:0] sum;
    r      = '0;
    hit    = -1;
    vacant = -1;
    if (dlen != {1'b0, psize} + HDR_BYTES) begin
      r.status = ST_LEN_ERR;
      return r;
    end
    if (idx >= cnt || int'(idx) >= int'(MAX_PARTS) || psize > payload_size) begin
      r.status = ST_BAD_PART;
      return r;
    end
    for (int s = 0; s < int'(OPEN_SLOTS); s++) begin
      if (slot_open[s]) begin
        if (hit < 0 && slot_entry[s].id == id) hit = s;
      end else if (vacant < 0) begin
        vacant = s;
      end
    end
    if (hit >= 0) begin
      r.slot = 3'(hit);
      if (slot_entry[hit].total != cnt) begin
        r.status = ST_COUNT_MISMATCH;
        return r;
      end
      // count a part and its bytes only the first time it shows up
      if (!part_map[hit][idx]) begin
        part_map[hit][idx]    = 1'b1;
        slot_entry[hit].seen  = slot_entry[hit].seen + 8'd1;
        sum                   = {1'b0, slot_entry[hit].bytes} + 25'(psize);
        slot_entry[hit].bytes = (sum > BYTES_MAX) ? BYTES_MAX[23:0] : sum[23:0];
      end
      r.offs  = idx * payload_size;
      r.total = slot_entry[hit].bytes;
      r.src   = src;
      if (slot_entry[hit].seen >= slot_entry[hit].total) begin
        slot_open[hit] = 1'b0;
        r.status       = ST_DONE;
        r.id           = id;
      end else begin
        r.status = ST_PARTIAL;
      end
      return r;
    end
    if (cnt == SINGLE_PART) begin
      r.status = ST_DONE;
      r.offs   = idx * payload_size;
      r.id     = id;
      r.total  = 24'(psize);
      r.src    = src;
      return r;
    end
    if (vacant < 0) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    slot_open[vacant]          = 1'b1;
    slot_entry[vacant].id      = id;
    slot_entry[vacant].total   = cnt;
    slot_entry[vacant].seen    = 8'd1;
    slot_entry[vacant].bytes   = 24'(psize);
    part_map[vacant]           = '0;
    part_map[vacant][idx]      = 1'b1;
    r.status = ST_PARTIAL;
    r.slot   = 3'(vacant);
    r.offs   = idx * payload_size;
    r.total  = 24'(psize);
    r.src    = src;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (fails < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void compare_result();
    result_t want;
    if (reassembly_q.size() == 0) begin
      if (fails < MAX_REPORTS)
        $display("%0t ns: result with nothing expected, expected none, actual status %0d",
                 $time, status_i);
      fails++;
      return;
    end
    want = reassembly_q.pop_front();
    check_field("status", 32'(want.status), 32'(status_i));
    check_field("slot", 32'(want.slot), 32'(slot_i));
    check_field("write_offset", 32'(want.offs), 32'(write_offset_i));
    check_field("done_id", want.id, done_id_i);
    check_field("total_size", 32'(want.total), 32'(total_size_i));
    check_field("last_source", 32'(want.src), 32'(last_source_i));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_size = PAYLOAD_SIZE_RST;
      for (int s = 0; s < int'(OPEN_SLOTS); s++) begin
        slot_open[s] = 1'b0;
        part_map[s]  = '0;
      end
      reassembly_q.delete();
      fails        = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // a fragment taken at this edge sees the stride from before this edge's write
      if (push_i && !full_i)
        reassembly_q.push_back(track_fragment(message_id_i, part_count_i, part_index_i,
                                              part_size_i, datagram_length_i, source_tag_i));
      if (cfg_valid_i && cfg_ready_i) payload_size = cfg_data_i;
      if (pop_i && !empty_i) compare_result();
      pending_o    <= reassembly_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfrt_pkg::*;

  localparam int PLANS        = 5;      // messages under construction at once
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 108;
  localparam int HOLD_CYCLES  = 200;    // long receiver hold-off to back up the block
  localparam int DRAIN_CYCLES = 24;     // idle tail before the final check
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic        push = 1'b0;
  logic        full;
  logic [31:0] message_id = '0;
  logic [7:0]  part_count = '0;
  logic [7:0]  part_index = '0;
  logic [15:0] part_size = '0;
  logic [16:0] datagram_length = '0;
  logic [7:0]  source_tag = '0;

  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [23:0] write_offset;
  logic [31:0] done_id;
  logic [23:0] total_size;
  logic [7:0]  last_source;

  int          fail_count;
  int          pending;

  // traffic shaping, owned by the stimulus process
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_served = 0;
  int          cycles = 0;
  logic [15:0] cur_payload = PAYLOAD_SIZE_RST;

  // per-plan bookkeeping for well-formed messages
  logic [31:0]  plan_id [PLANS];
  logic [7:0]   plan_cnt [PLANS];
  logic [255:0] plan_sent [PLANS];
  int           plan_left [PLANS];

  datagram_fragment_reassembly_tracker_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .message_id_i     (message_id),
    .part_count_i     (part_count),
    .part_index_i     (part_index),
    .part_size_i      (part_size),
    .datagram_length_i(datagram_length),
    .source_tag_i     (source_tag),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status),
    .slot_o           (slot),
    .write_offset_o   (write_offset),
    .done_id_o        (done_id),
    .total_size_o     (total_size),
    .last_source_o    (last_source)
  );

  reassembly_checker reassembly_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .push_i           (push),
    .full_i           (full),
    .message_id_i     (message_id),
    .part_count_i     (part_count),
    .part_index_i     (part_index),
    .part_size_i      (part_size),
    .datagram_length_i(datagram_length),
    .source_tag_i     (source_tag),
    .empty_i          (empty),
    .pop_i            (pop),
    .status_i         (status),
    .slot_i           (slot),
    .write_offset_i   (write_offset),
    .done_id_i        (done_id),
    .total_size_i     (total_size),
    .last_source_i    (last_source),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always #5 clk = ~clk;

  // Abort on a hang: count every cycle and give up far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: pop at random per the current stall rate. When the stimulus posts a
  // hold-off request, drop pop for a long stretch counted here so the block backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one fragment header; idle first per the sender rate, then hold push until the
  // transaction is taken. Push stays high on exit so back-to-back items leave no bubble.
  task automatic send_fragment(input logic [31:0] id, input logic [7:0] cnt,
                               input logic [7:0] idx, input logic [15:0] psize,
                               input logic [16:0] dlen, input logic [7:0] src);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    message_id      <= id;
    part_count      <= cnt;
    part_index      <= idx;
    part_size       <= psize;
    datagram_length <= dlen;
    source_tag      <= src;
    do @(posedge clk); while (full);
  endtask

  // Same, with a datagram length that matches the payload plus header.
  task automatic send_good(input logic [31:0] id, input logic [7:0] cnt, input logic [7:0] idx,
                           input logic [15:0] psize, input logic [7:0] src);
    send_fragment(id, cnt, idx, psize, {1'b0, psize} + HDR_BYTES, src);
  endtask

  // Drop push and wait until every expected result has been taken.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_payload_size(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_payload = value;
  endtask

  function automatic logic [15:0] legal_size();
    if ($urandom_range(0, 9) == 0) return cur_payload;
    return 16'($urandom_range(0, cur_payload));
  endfunction

  // Mostly short messages; now and then a long one to exercise the upper bitmap words.
  function automatic void new_plan(input int p);
    plan_id[p]   = $urandom;
    plan_cnt[p]  = ($urandom_range(0, 99) < 2) ? 8'($urandom_range(7, 130))
                                               : 8'($urandom_range(2, 6));
    plan_sent[p] = '0;
    plan_left[p] = plan_cnt[p];
  endfunction

  // Send part idx of plan p and start a fresh message once the last one goes out.
  task automatic send_part(input int p, input int idx);
    if (!plan_sent[p][idx]) begin
      plan_sent[p][idx] = 1'b1;
      plan_left[p]--;
    end
    send_good(plan_id[p], plan_cnt[p], 8'(idx), legal_size(), 8'($urandom));
    if (plan_left[p] == 0) new_plan(p);
  endtask

  task automatic random_fragment();
    int          kind;
    int          p;
    int          u;
    logic [7:0]  cnt;
    logic [15:0] psize;
    kind = $urandom_range(0, 99);
    p    = $urandom_range(0, PLANS - 1);
    if (kind < 65 || (kind < 77 && plan_left[p] == plan_cnt[p])) begin
      // next unsent part, in random order
      u = $urandom_range(0, plan_cnt[p] - 1);
      while (plan_sent[p][u]) u = (u + 1) % plan_cnt[p];
      send_part(p, u);
    end else if (kind < 72) begin
      // any part of an open message, often a repeat
      send_part(p, $urandom_range(0, plan_cnt[p] - 1));
    end else if (kind < 77) begin
      // open id with the wrong part count
      cnt = (plan_cnt[p] == 8'd255) ? 8'd2 : plan_cnt[p] + 8'd1;
      send_good(plan_id[p], cnt, 8'd0, legal_size(), 8'($urandom));
    end else if (kind < 82) begin
      send_good($urandom, SINGLE_PART, 8'd0, legal_size(), 8'($urandom));
    end else if (kind < 87) begin
      // length off by a nonzero amount modulo the field width
      psize = 16'($urandom);
      send_fragment(plan_id[p], plan_cnt[p], 8'd0, psize,
                    {1'b0, psize} + HDR_BYTES + 17'($urandom_range(1, 131071)),
                    8'($urandom));
    end else if (kind < 91 || (kind < 95 && cur_payload == 16'hFFFF)) begin
      cnt = 8'($urandom_range(0, 255));
      send_good($urandom, cnt, 8'($urandom_range(cnt, 255)), legal_size(), 8'($urandom));
    end else if (kind < 95) begin
      // part larger than the configured stride
      send_good(plan_id[p], plan_cnt[p], 8'd0, 16'($urandom_range(cur_payload + 1, 65535)),
                8'($urandom));
    end else begin
      send_fragment($urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                    17'($urandom_range(0, 131071)), 8'($urandom));
    end
  endtask

  initial begin
    for (int p = 0; p < PLANS; p++) new_plan(p);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks at the reset stride of 500.
    send_good(32'h1234_5678, SINGLE_PART, 8'd0, 16'd500, 8'h00);   // completes at once
    send_fragment(32'h1234_5679, 8'd2, 8'd0, 16'd10, 17'd10, 8'h11); // length error
    send_good(32'h0000_0042, 8'd3, 8'd3, 16'd20, 8'h22);           // index at the count
    send_good(32'h0000_0043, 8'd0, 8'd0, 16'd20, 8'h33);           // zero part count
    send_good(32'h0000_0044, 8'd2, 8'd0, 16'd501, 8'h44);          // oversize part
    // Fill every slot, overflow the table, then repeat and mismatch against slot 0.
    for (int b = 0; b < 8; b++) send_good(32'(b), 8'd2, 8'd0, 16'(100 + b), 8'(b));
    send_good(32'h0000_ABCD, 8'd2, 8'd1, 16'd5, 8'h55);
    send_good(32'h0000_0000, 8'd2, 8'd0, 16'd50, 8'h66);
    send_good(32'h0000_0000, 8'd3, 8'd0, 16'd50, 8'h77);
    // Finish all eight and free the table.
    for (int b = 0; b < 8; b++) send_good(32'(b), 8'd2, 8'd1, 16'd500, 8'hF0 | 8'(b));

    // Widest stride: largest part, highest index, all-ones id and source.
    drain_results();
    write_payload_size(16'hFFFF);
    send_good(32'hFFFF_FFFF, 8'd255, 8'd254, 16'hFFFF, 8'hFF);
    send_good(32'hFFFF_FFFF, 8'd255, 8'd255, 16'hFFFF, 8'h00);
    send_good(32'hFFFF_FFFF, 8'd255, 8'd0, 16'd0, 8'h00);

    // Random phases: change the stride and the idling pattern between them.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        1: write_payload_size(16'd1);
        2: write_payload_size(16'd0);
        3: write_payload_size(16'($urandom_range(2, 65534)));
        4: write_payload_size(PAYLOAD_SIZE_RST);
        5: write_payload_size(16'($urandom_range(2, 64)));
        default: ;
      endcase
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      // Back up the block once while the sender keeps offering at full rate.
      if (ph == 0) hold_req++;
      repeat (PHASE_ITEMS) random_fragment();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
